// File: hw/rtl/i24rq_pkg.sv
// ----------------------------------------------------------------------------
// i24rq_pkg
// Shared types and constants of the 24-bit accumulator to int8 requantizer.
// ----------------------------------------------------------------------------
package i24rq_pkg;

    // Widths of the fields and of the internal values.
    localparam int HALF_W  = 16;
    localparam int MULT_W  = 32;
    localparam int ACC_W   = 24;
    localparam int WORD_W  = 32;
    localparam int SHIFT_W = 6;
    localparam int OUT_W   = 8;
    localparam int PROD_W  = ACC_W + MULT_W;

    // Rounding constant of the doubling high multiply and its shift.
    localparam logic signed [PROD_W-1:0] DHM_NUDGE = PROD_W'(64'sd1 << 30);
    localparam int DHM_SHIFT = 31;

    // Saturation limits of the result.
    localparam logic signed [WORD_W-1:0] Q8_MAX = 32'sd127;
    localparam logic signed [WORD_W-1:0] Q8_MIN = -32'sd128;

    typedef logic        [HALF_W-1:0]  half_t;
    typedef logic signed [HALF_W-1:0]  shalf_t;
    typedef logic signed [MULT_W-1:0]  mult_t;
    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [SHIFT_W-1:0] shift_t;
    typedef logic signed [OUT_W-1:0]   q8_t;

endpackage

// File: hw/rtl/i24rq_dhm.sv
// ----------------------------------------------------------------------------
// i24rq_dhm
// Rebuilds the 24-bit accumulator and applies the rounding doubling high
// multiply in two register stages: product, then nudge and high slice.
// ----------------------------------------------------------------------------
module i24rq_dhm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  i24rq_pkg::half_t  low_half,
    input  i24rq_pkg::shalf_t high_half,
    input  i24rq_pkg::mult_t  multiplier,
    output logic              out_valid,
    input  logic              out_ready,
    output i24rq_pkg::word_t  q
);
    import i24rq_pkg::*;

    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] nudged;
    word_t                    q_next;
    word_t                    q_reg;
    logic                     a_valid_reg;
    logic                     b_valid_reg;
    logic                     a_ready;
    logic                     b_ready;

    // A stage takes a new word when it is empty or its word moves on.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Accumulator rebuild and the signed 24 by 32 product.
    assign acc       = {high_half, low_half[7:0]};
    assign prod_next = PROD_W'(acc) * PROD_W'(multiplier);

    // Adding 2^30 and taking the arithmetic high slice rounds both signs
    // exactly as the published nudge with truncation toward zero does.
    assign nudged = prod_reg + DHM_NUDGE;
    assign q_next = WORD_W'($signed(nudged[PROD_W-1:DHM_SHIFT]));

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (b_ready && a_valid_reg) begin
            q_reg <= q_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign q         = q_reg;

endmodule

// File: hw/rtl/i24rq_rshift.sv
// ----------------------------------------------------------------------------
// i24rq_rshift
// Rounding right shift or wrapping left shift by the configured amount,
// then saturation to int8, in two register stages.
// ----------------------------------------------------------------------------
module i24rq_rshift (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  i24rq_pkg::word_t  q,
    input  i24rq_pkg::shift_t shift_amount,
    output logic              out_valid,
    input  logic              out_ready,
    output i24rq_pkg::q8_t    quantized
);
    import i24rq_pkg::*;

    logic [SHIFT_W-1:0] neg_sh;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  rem;
    logic [WORD_W-1:0]  thr;
    word_t              val_next;
    logic               rnd_next;
    word_t              val_reg;
    logic               rnd_reg;
    word_t              sum;
    q8_t                sat_next;
    q8_t                sat_reg;
    logic               c_valid_reg;
    logic               d_valid_reg;
    logic               c_ready;
    logic               d_ready;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    // Shift stage: floor of the right shift plus a round-up flag, or the
    // wrapped left shift. A left shift by 32 clears the word.
    assign neg_sh = SHIFT_W'(0) - shift_amount;
    assign mask   = (WORD_W'(1) << shift_amount[4:0]) - WORD_W'(1);
    assign rem    = q & mask;
    assign thr    = (mask >> 1) + WORD_W'(q[WORD_W-1]);

    always_comb begin
        if (shift_amount[SHIFT_W-1] || shift_amount == '0) begin
            rnd_next = 1'b0;
            if (neg_sh[SHIFT_W-1]) begin
                val_next = '0;
            end else begin
                val_next = q << neg_sh[4:0];
            end
        end else begin
            val_next = q >>> shift_amount[4:0];
            rnd_next = rem > thr;
        end
    end

    // Saturation stage.
    assign sum = val_reg + WORD_W'(rnd_reg);

    always_comb begin
        if (sum > Q8_MAX) begin
            sat_next = OUT_W'(Q8_MAX);
        end else if (sum < Q8_MIN) begin
            sat_next = OUT_W'(Q8_MIN);
        end else begin
            sat_next = sum[OUT_W-1:0];
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            val_reg <= val_next;
            rnd_reg <= rnd_next;
        end
        if (d_ready && c_valid_reg) begin
            sat_reg <= sat_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign quantized = sat_reg;

endmodule

// File: hw/rtl/int24_requantize_to_int8.sv
// ----------------------------------------------------------------------------
// int24_requantize_to_int8
// Requantizes a 24-bit matrix accumulator to a saturated signed 8-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid / s_ready) carries one word: the two 16-bit
//   accumulator halves and the column's Q31 multiplier. The output channel
//   (m_valid / m_ready) returns one quantized int8 word for each input word,
//   in order.
//   The shift amount is written through cfg_we / cfg_wdata and takes effect
//   at the next edge; write it only while no word is in flight.
//   An accepted word enters the first of four register stages (product,
//   high slice, shift, saturation) and moves on when the next stage is free.
//   Throughput is one word per cycle while m_ready is high. Each stage
//   holds a valid bit and advances when the next stage is empty or
//   moving, so bubbles are filled and input is taken while a finished
//   word waits at the output.
//   When the receiver stalls, words pile up in the stages and s_ready falls
//   only once all four stages are full; nothing is dropped or repeated.
//   Reset (aresetn low at a clock edge) empties the pipeline and sets the
//   shift amount to zero.
// ----------------------------------------------------------------------------
module int24_requantize_to_int8 (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  i24rq_pkg::shift_t cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  i24rq_pkg::half_t  s_low_half,
    input  i24rq_pkg::shalf_t s_high_half,
    input  i24rq_pkg::mult_t  s_multiplier,
    output logic              m_valid,
    input  logic              m_ready,
    output i24rq_pkg::q8_t    m_quantized
);
    import i24rq_pkg::*;

    shift_t shift_amount_reg;
    shift_t shift_amount_next;
    logic   mid_valid;
    logic   mid_ready;
    word_t  mid_q;

    // Shift amount register.
    assign shift_amount_next = cfg_we ? cfg_wdata : shift_amount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_amount_reg <= '0;
        end else begin
            shift_amount_reg <= shift_amount_next;
        end
    end

    // Doubling high multiply stages.
    i24rq_dhm u_dhm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .low_half   (s_low_half),
        .high_half  (s_high_half),
        .multiplier (s_multiplier),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .q          (mid_q)
    );

    // Shift and saturation stages.
    i24rq_rshift u_rshift (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (mid_valid),
        .in_ready     (mid_ready),
        .q            (mid_q),
        .shift_amount (shift_amount_reg),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .quantized    (m_quantized)
    );

`ifndef SYNTH
    // Input back-pressure only arises when the output holds a word.
    a_stall_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low while output is empty");

    // The middle hand-off stalls only when the output is blocked.
    a_mid_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid && !mid_ready) |-> (m_valid && !m_ready))
        else $error("internal stall without output stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !mid_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule
